/* hdl/ffsc_pkg.sv */
// Shared constants, result type and frame classification for the frame sync classifier.
package ffsc_pkg;

    localparam int FRAME_LEN  = 9;
    localparam int BODY_BYTES = FRAME_LEN - 1;
    localparam int FILL_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W      = $clog2(BODY_BYTES);
    localparam int CLASS_W    = 4;
    localparam int BODY_W     = 8 * BODY_BYTES;

    localparam logic [7:0] HEAD_CMD   = 8'h22;
    localparam logic [7:0] HEAD_VALUE = 8'h01;
    localparam logic [7:0] TAIL_BYTE  = 8'hAA;
    localparam logic [7:0] TYPE_MOVE  = 8'h58;
    localparam logic [7:0] TYPE_USQ   = 8'h01;
    localparam logic [7:0] TYPE_USR   = 8'h02;
    localparam logic [7:0] TYPE_IR    = 8'h03;
    localparam logic [7:0] MOVE_FWD   = 8'h01;
    localparam logic [7:0] MOVE_BACK  = 8'h10;
    localparam logic [7:0] MOVE_TURN  = 8'h11;
    localparam logic [7:0] MOVE_HALT  = 8'h00;
    localparam logic [7:0] TURN_LEFT  = 8'h01;
    localparam logic [7:0] TURN_RIGHT = 8'h00;

    localparam logic [CLASS_W-1:0] CLS_FWD        = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_BACK       = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_LEFT       = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_RIGHT      = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_HALT       = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_USQUERY    = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_US1        = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_US2        = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_US3        = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_IR         = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_USVALUE    = 4'd10;
    localparam logic [CLASS_W-1:0] CLS_UNK_FRAME  = 4'd11;
    localparam logic [CLASS_W-1:0] CLS_UNK_PACKET = 4'd12;

    typedef struct packed {
        logic               found;
        logic [CLASS_W-1:0] cls;
        logic [BODY_W-1:0]  body;
    } res_t;

    function automatic logic [CLASS_W-1:0] classify(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b6
    );
        logic [CLASS_W-1:0] cls;
        begin
            cls = CLS_UNK_FRAME;
            if (b0 == HEAD_CMD)
            begin
                if (b1 == TYPE_MOVE)
                begin
                    if (b6 == MOVE_FWD)
                        cls = CLS_FWD;
                    else if (b6 == MOVE_BACK)
                        cls = CLS_BACK;
                    else if (b6 == MOVE_TURN && b2 == TURN_LEFT)
                        cls = CLS_LEFT;
                    else if (b6 == MOVE_TURN && b2 == TURN_RIGHT)
                        cls = CLS_RIGHT;
                    else if (b6 == MOVE_HALT)
                        cls = CLS_HALT;
                end
                else if (b1 == TYPE_USQ)
                    cls = CLS_USQUERY;
                else if (b1 == TYPE_USR)
                begin
                    case (b2)
                        8'd1:    cls = CLS_US1;
                        8'd2:    cls = CLS_US2;
                        8'd3:    cls = CLS_US3;
                        default: cls = CLS_UNK_FRAME;
                    endcase
                end
                else if (b1 == TYPE_IR)
                    cls = CLS_IR;
            end
            else if (b0 == HEAD_VALUE)
                cls = CLS_USVALUE;
            return cls;
        end
    endfunction

endpackage

/* hdl/ffsc_window.sv */
// Sliding byte window, frame match and per-item result for the frame sync classifier.
module ffsc_window (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_value,
    input  logic          last_byte,
    output ffsc_pkg::res_t res
);
    import ffsc_pkg::*;

    logic [7:0]        win_reg  [BODY_BYTES];
    logic [7:0]        win_next [BODY_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              seen_reg;
    logic              seen_next;
    logic              full;
    logic              match;
    logic [BODY_W-1:0] body;

    assign full  = (fill_reg == FILL_W'(BODY_BYTES));
    assign match = full && (win_reg[0] == HEAD_CMD || win_reg[0] == HEAD_VALUE)
                   && (byte_value == TAIL_BYTE);

    always_comb
    begin
        for (int i = 0; i < BODY_BYTES; i++)
            body[BODY_W-1-8*i -: 8] = win_reg[i];
    end

    always_comb
    begin
        res.found = 1'b0;
        res.cls   = CLS_UNK_PACKET;
        res.body  = '0;
        if (match)
        begin
            res.found = 1'b1;
            res.cls   = classify(win_reg[0], win_reg[1], win_reg[2], win_reg[6]);
            res.body  = body;
        end
        else if (last_byte && !seen_reg)
            res.found = 1'b1;
    end

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        seen_next = seen_reg;
        if (step)
        begin
            if (last_byte)
            begin
                fill_next = '0;
                seen_next = 1'b0;
            end
            else if (match)
            begin
                fill_next = '0;
                seen_next = 1'b1;
            end
            else if (full)
            begin
                // drop the oldest byte and slide the new one in at the end
                for (int i = 0; i < BODY_BYTES - 1; i++)
                    win_next[i] = win_reg[i+1];
                win_next[BODY_BYTES-1] = byte_value;
            end
            else
            begin
                win_next[fill_reg[IDX_W-1:0]] = byte_value;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* hdl/ffsc_result_reg.sv */
// Result register holding one classified item toward the output channel.
module ffsc_result_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  ffsc_pkg::res_t                  res,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [ffsc_pkg::CLASS_W-1:0]    frame_class,
    output logic [ffsc_pkg::BODY_W-1:0]     frame_body
);
    import ffsc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [CLASS_W-1:0] cls_reg;
    logic [BODY_W-1:0]  body_reg;

    always_comb
    begin
        if (step)
            valid_next = res.found;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.found)
        begin
            cls_reg  <= res.cls;
            body_reg <= res.body;
        end
    end

    assign out_valid   = valid_reg;
    assign frame_class = cls_reg;
    assign frame_body  = body_reg;

endmodule

/* hdl/fixed_frame_sync_classifier_unit.sv */
// Top level of the fixed frame sync classifier: input register, window logic, result register.
//
// Usage:
//   Input channel: byte_value and last_byte with in_valid / in_stall. One
//   item is one byte of a serial packet; last_byte marks the packet's end.
//   Output channel: frame_class and frame_body with out_valid / out_stall.
//   A frame (head 0x22 or 0x01, tail 0xAA, nine bytes) yields one item with
//   its class and first eight bytes; a packet that ends with no frame in it
//   yields one unknown-packet item with a zero body. Other bytes yield none.
//   Path: an accepted byte passes through the input register, then its result
//   is registered in the result register.
//   Throughput: one byte per cycle while the output is not stalled; the window
//   update and the compare sit between the input register and the result register.
//   Stall: a waiting result holds the result register; the input register
//   still takes one more byte, and in_stall rises only when it is full too.
//   Reset: clears the valid flags, the fill count and the frame-seen flag;
//   the window bytes need no reset because only the filled part is read.
module fixed_frame_sync_classifier_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   byte_value,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ffsc_pkg::CLASS_W-1:0] frame_class,
    output logic [ffsc_pkg::BODY_W-1:0]  frame_body
);
    import ffsc_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;
    logic       accept;
    logic       step;
    res_t       res;

    // advance when the result register is empty or being drained this cycle
    assign advance  = !out_valid || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign step     = in_valid_reg && advance;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // hold the captured item until it moves into the window logic
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_value;
            last_reg <= last_byte;
        end
    end

    ffsc_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (byte_reg),
        .last_byte  (last_reg),
        .res        (res)
    );

    ffsc_result_reg u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .res         (res),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .frame_class (frame_class),
        .frame_body  (frame_body)
    );

endmodule

/* hdl/ffsc_checker.sv */
// Port-level checker for the frame sync classifier and its bind to the top level.
module ffsc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ffsc_pkg::CLASS_W-1:0] frame_class,
    input logic [ffsc_pkg::BODY_W-1:0]  frame_body
);
    import ffsc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_class) && $stable(frame_body))
        else $error("stalled result item changed");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_class <= CLS_UNK_PACKET)
        else $error("frame class out of range");

    a_unk_packet_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_class == CLS_UNK_PACKET |-> frame_body == '0)
        else $error("unknown packet with nonzero body");

    a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_class != CLS_UNK_PACKET
        |-> frame_body[BODY_W-1 -: 8] == HEAD_CMD || frame_body[BODY_W-1 -: 8] == HEAD_VALUE)
        else $error("frame result without a valid head byte");

endmodule

bind fixed_frame_sync_classifier_unit ffsc_checker u_ffsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_class (frame_class),
    .frame_body  (frame_body)
);

/* sim/fixed_frame_sync_classifier_unit_tb.sv */
// Self-checking testbench for the fixed frame sync classifier: directed table, then random packets.
module fixed_frame_sync_classifier_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffsc_pkg::*;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASE_ITEMS   = 257;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_CAP    = 50;

    // One classifier result: class code and the first eight frame bytes.
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [BODY_W-1:0]  body;
    } frame_result_t;

    // One row of the directed table; typed rows carry the result to expect.
    typedef struct {
        logic [7:0]         b;
        logic               last;
        bit                 typed;
        logic [CLASS_W-1:0] cls;
        logic [BODY_W-1:0]  body;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         byte_value;
    logic               last_byte;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CLASS_W-1:0] frame_class;
    logic [BODY_W-1:0]  frame_body;

    // Shadow of the sync window: bytes, fill level and the per-packet frame flag.
    logic [7:0]    win [FRAME_LEN];
    int            fill;
    bit            seen;

    frame_result_t pending_frames[$];
    logic [7:0]    pkt_bytes[$];
    stim_row_t     stim_rows[DIRECTED_ROWS];

    int            idle_pct;
    int            stall_pct;
    int            items_sent;
    int            fail_count;
    int unsigned   cycle_count;

    fixed_frame_sync_classifier_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_class (frame_class),
        .frame_body  (frame_body)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Count and report a failure; keep the log short if the block is badly broken.
    task automatic note_fail(input string msg);
        if (fail_count < REPORT_CAP)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Decode the class of a full window that passed the head and tail check.
    function automatic logic [CLASS_W-1:0] frame_kind();
        logic [CLASS_W-1:0] k;
        k = CLS_UNK_FRAME;
        if (win[0] == HEAD_VALUE)
            k = CLS_USVALUE;
        else if (win[0] == HEAD_CMD)
        begin
            case (win[1])
                TYPE_MOVE:
                begin
                    // Motion commands key on byte 6; a turn also needs byte 2.
                    case (win[6])
                        MOVE_FWD:  k = CLS_FWD;
                        MOVE_BACK: k = CLS_BACK;
                        MOVE_HALT: k = CLS_HALT;
                        MOVE_TURN:
                        begin
                            if (win[2] == TURN_LEFT)
                                k = CLS_LEFT;
                            else if (win[2] == TURN_RIGHT)
                                k = CLS_RIGHT;
                        end
                        default: k = CLS_UNK_FRAME;
                    endcase
                end
                TYPE_USQ: k = CLS_USQUERY;
                TYPE_USR:
                begin
                    if (win[2] >= 8'd1 && win[2] <= 8'd3)
                        k = CLS_US1 + 4'(win[2] - 8'd1);
                end
                TYPE_IR: k = CLS_IR;
                default: k = CLS_UNK_FRAME;
            endcase
        end
        return k;
    endfunction

    // Advance the shadow window by one accepted byte and say what result it yields.
    task automatic step_window(input logic [7:0] b, input logic last,
                               output bit hit, output frame_result_t res);
        int i;
        hit = 1'b0;
        res = '0;
        win[fill] = b;
        fill++;
        if (fill == FRAME_LEN)
        begin
            if ((win[0] == HEAD_CMD || win[0] == HEAD_VALUE) && win[FRAME_LEN-1] == TAIL_BYTE)
            begin
                res.cls = frame_kind();
                for (i = 0; i < BODY_BYTES; i++)
                    res.body = {res.body[BODY_W-9:0], win[i]};
                hit  = 1'b1;
                seen = 1'b1;
                fill = 0;
                for (i = 0; i < FRAME_LEN; i++)
                    win[i] = 8'h00;
            end
            else
            begin
                // Drop the oldest byte and slide on.
                for (i = 0; i < FRAME_LEN - 1; i++)
                    win[i] = win[i+1];
                win[FRAME_LEN-1] = 8'h00;
                fill = FRAME_LEN - 1;
            end
        end
        if (last)
        begin
            if (!seen && !hit)
            begin
                hit      = 1'b1;
                res.cls  = CLS_UNK_PACKET;
                res.body = '0;
            end
            for (i = 0; i < FRAME_LEN; i++)
                win[i] = 8'h00;
            fill = 0;
            seen = 1'b0;
        end
    endtask

    // Offer one byte, idling first at the current rate; hold it until taken.
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input bit typed, input frame_result_t typed_res);
        bit            hit;
        frame_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Item taken at this edge: advance the shadow window.
        step_window(b, last, hit, res);
        if (typed)
            pending_frames.push_back(typed_res);
        else if (hit)
            pending_frames.push_back(res);
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has come out.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    // Append a well-formed frame of a random class with random filler bytes.
    task automatic build_frame();
        logic [7:0]         f [FRAME_LEN];
        logic [CLASS_W-1:0] kind;
        int                 i;
        for (i = 0; i < FRAME_LEN; i++)
            f[i] = 8'($urandom_range(255));
        f[FRAME_LEN-1] = TAIL_BYTE;
        f[0] = HEAD_CMD;
        kind = 4'($urandom_range(CLS_UNK_FRAME));
        case (kind)
            CLS_FWD:
            begin
                f[1] = TYPE_MOVE;
                f[6] = MOVE_FWD;
            end
            CLS_BACK:
            begin
                f[1] = TYPE_MOVE;
                f[6] = MOVE_BACK;
            end
            CLS_LEFT:
            begin
                f[1] = TYPE_MOVE;
                f[6] = MOVE_TURN;
                f[2] = TURN_LEFT;
            end
            CLS_RIGHT:
            begin
                f[1] = TYPE_MOVE;
                f[6] = MOVE_TURN;
                f[2] = TURN_RIGHT;
            end
            CLS_HALT:
            begin
                f[1] = TYPE_MOVE;
                f[6] = MOVE_HALT;
            end
            CLS_USQUERY: f[1] = TYPE_USQ;
            CLS_US1, CLS_US2, CLS_US3:
            begin
                f[1] = TYPE_USR;
                f[2] = 8'(kind - CLS_US1) + 8'd1;
            end
            CLS_IR:      f[1] = TYPE_IR;
            CLS_USVALUE: f[0] = HEAD_VALUE;
            default:
            begin
                // Unknown frames: odd type byte, odd motion code, or odd reply slot.
                case ($urandom_range(2))
                    0: ;
                    1:
                    begin
                        f[1] = TYPE_MOVE;
                        f[6] = ($urandom_range(1) == 0) ? MOVE_TURN : f[6];
                    end
                    default: f[1] = TYPE_USR;
                endcase
            end
        endcase
        for (i = 0; i < FRAME_LEN; i++)
            pkt_bytes.push_back(f[i]);
    endtask

    task automatic push_noise(input int n);
        repeat (n)
            pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Send one random packet: mostly framed traffic, some noise, some broken frames.
    task automatic send_random_packet();
        int roll;
        int i;
        pkt_bytes.delete();
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            // Zero trailing bytes puts the end of packet on the frame tail.
            push_noise($urandom_range(3));
            build_frame();
            if ($urandom_range(2) == 0)
                build_frame();
            push_noise($urandom_range(2));
        end
        else if (roll < 85)
            push_noise($urandom_range(1, 20));
        else
        begin
            build_frame();
            if ($urandom_range(1) == 0)
                void'(pkt_bytes.pop_back());
            else
                pkt_bytes[pkt_bytes.size()-1] = TAIL_BYTE ^ 8'(1 << $urandom_range(7));
            push_noise($urandom_range(4));
        end
        for (i = 0; i < pkt_bytes.size(); i++)
            push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, '0);
    endtask

    // Receiver: check each taken result against the oldest prediction, then pick the stall.
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
                note_fail($sformatf("unexpected result class %0d body %h",
                                    frame_class, frame_body));
            else
            begin
                want = pending_frames.pop_front();
                if (frame_class !== want.cls)
                    note_fail($sformatf("frame_class expected %0d actual %0d",
                                        want.cls, frame_class));
                if (frame_body !== want.body)
                    note_fail($sformatf("frame_body expected %h actual %h",
                                        want.body, frame_body));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run as failed once the cycle limit is reached.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fixed_frame_sync_classifier_unit_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int            row;
        int            phase;
        frame_result_t typed_res;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_value = 8'h00;
        last_byte  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        fail_count = 0;
        fill       = 0;
        seen       = 1'b0;
        for (row = 0; row < FRAME_LEN; row++)
            win[row] = 8'h00;

        // Directed rows: extreme one-byte packets, a short packet, a frame ending
        // on the last byte, a frame found after one slide, and a packet end after
        // a frame that must stay silent.
        stim_rows = '{
            '{8'hFF, 1'b1, 1'b1, CLS_UNK_PACKET, 64'h0},
            '{8'h00, 1'b1, 1'b1, CLS_UNK_PACKET, 64'h0},
            '{8'h22, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hAA, 1'b1, 1'b1, CLS_UNK_PACKET, 64'h0},
            '{8'h22, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h58, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h01, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h00, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h01, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h00, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hAA, 1'b1, 1'b1, CLS_FWD, 64'h225801FF00FF0100},
            '{8'h80, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'h01, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hFF, 1'b0, 1'b0, CLS_FWD, 64'h0},
            '{8'hAA, 1'b0, 1'b1, CLS_USVALUE, 64'h01FFFFFFFFFFFFFF},
            '{8'h55, 1'b1, 1'b0, CLS_FWD, 64'h0}
        };

        // Hold reset, then release it once for the whole run.
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            typed_res.cls  = stim_rows[row].cls;
            typed_res.body = stim_rows[row].body;
            push_byte(stim_rows[row].b, stim_rows[row].last, stim_rows[row].typed, typed_res);
        end
        wait_drain();

        // Random phases: free flow, sparse sender, slow receiver, then both.
        // Drain between phases so the sender pauses until all results are in.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default:
                begin
                    idle_pct  = 32;
                    stall_pct = 32;
                end
            endcase
            while (items_sent < DIRECTED_ROWS + (phase + 1) * PHASE_ITEMS)
                send_random_packet();
            wait_drain();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_frames.size() == 0)
            $display("fixed_frame_sync_classifier_unit_tb passed");
        else
            $display("fixed_frame_sync_classifier_unit_tb failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/ffsc_pkg.sv
hdl/ffsc_window.sv
hdl/ffsc_result_reg.sv
hdl/fixed_frame_sync_classifier_unit.sv
hdl/ffsc_checker.sv
sim/fixed_frame_sync_classifier_unit_tb.sv
